// ===== hdl/acem_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the axis center/expo mapper.
package acem_pkg;

	localparam int Q_FRAC  = 30;
	localparam int Q_W     = 31;
	localparam int N_ROOTS = 12;
	localparam int EXP_W   = 16;
	localparam int OUT_W   = 32;
	localparam int MAG_W   = 33;

	localparam logic [Q_W-1:0]   ONE_Q    = 31'h4000_0000;
	localparam logic [EXP_W-1:0] EXP_ONE  = 16'd4096;
	localparam logic [EXP_W-1:0] EXP_TINY = 16'd40;

	typedef logic [Q_W-1:0] q_t;

	typedef struct packed {
		logic             upper;
		logic             fault;
		q_t [N_ROOTS:0]   roots;
	} side_t;

	typedef enum logic [2:0] {
		REG_IN_MIN,
		REG_IN_MAX,
		REG_IN_CENTER,
		REG_OUT_MIN,
		REG_OUT_CENTER,
		REG_OUT_MAX,
		REG_REVERSE,
		REG_EXPONENT
	} reg_idx_t;

endpackage
`default_nettype wire

// ===== hdl/acem_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Stream interfaces for raw samples and mapped results.
interface acem_sample_if #(parameter int SAMPLE_BITS = 16) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface acem_result_if import acem_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] mapped_value;
	logic                    span_fault;

	modport source (output valid, output mapped_value, output span_fault, input ready);
	modport sink   (input valid, input mapped_value, input span_fault, output ready);
endinterface
`default_nettype wire

// ===== hdl/axis_center_expo_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Joystick axis calibration: clamp, center split, expo curve, output scaling.
//
//   port      dir   contents
//   axis      in    sample (signed, SAMPLE_BITS)
//   mapped    out   mapped_value (signed Q16.16), span_fault
//   wr_*      in    register write: wr_en, wr_index, wr_data
//
// One transaction per cycle while mapped does not stall; stages: front end 1, divider 31,
// twelve chained 31-stage square roots, 16 power stages, scale 1, output 1.
// The square-root chain makes up most of the pipeline depth.
// Reset clears valid bits and loads register defaults.
// A stall on mapped freezes the whole pipeline; axis.ready drops with it.
module axis_center_expo_mapper import acem_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire reg_idx_t         wr_index,
	input  wire logic [OUT_W-1:0] wr_data,
	acem_sample_if.sink           axis,
	acem_result_if.source         mapped
);

	localparam int SB        = SAMPLE_BITS;
	localparam int SW        = SAMPLE_BITS + 1;
	localparam int DIV_STEPS = Q_W;
	localparam int POW_STEPS = EXP_W;
	localparam int SUM_W     = OUT_W + 2;

	typedef struct packed {
		logic upper;
		logic zero;
		logic neg;
		logic sat;
	} flags_t;

	// configuration
	logic signed [SB-1:0]    in_min_q, in_max_q, in_center_q;
	logic signed [OUT_W-1:0] out_min_q, out_center_q, out_max_q;
	logic                    reverse_q;
	logic [EXP_W-1:0]        cexp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_min_q     <= '0;
			in_max_q     <= SB'(1023);
			in_center_q  <= SB'(512);
			out_min_q    <= 32'shFFFF_0000;
			out_center_q <= '0;
			out_max_q    <= 32'sh0001_0000;
			reverse_q    <= 1'b0;
			cexp_q       <= EXP_ONE;
		end else if (wr_en) begin
			case (wr_index)
				REG_IN_MIN:     in_min_q     <= wr_data[SB-1:0];
				REG_IN_MAX:     in_max_q     <= wr_data[SB-1:0];
				REG_IN_CENTER:  in_center_q  <= wr_data[SB-1:0];
				REG_OUT_MIN:    out_min_q    <= wr_data;
				REG_OUT_CENTER: out_center_q <= wr_data;
				REG_OUT_MAX:    out_max_q    <= wr_data;
				REG_REVERSE:    reverse_q    <= wr_data[0];
				REG_EXPONENT:   cexp_q       <= wr_data[EXP_W-1:0];
				default: ;
			endcase
		end
	end

	logic [EXP_W-1:0] exp_eff;
	assign exp_eff = (cexp_q <= EXP_TINY) ? EXP_ONE : cexp_q;

	// endpoint deltas, derived from configuration
	logic signed [OUT_W-1:0] endp_up, endp_lo;
	logic signed [MAG_W-1:0] diff_up, diff_lo;
	logic [MAG_W-1:0]        mag_up_q, mag_lo_q;
	logic                    neg_up_q, neg_lo_q;

	assign endp_up = reverse_q ? out_min_q : out_max_q;
	assign endp_lo = reverse_q ? out_max_q : out_min_q;
	assign diff_up = MAG_W'(endp_up) - MAG_W'(out_center_q);
	assign diff_lo = MAG_W'(endp_lo) - MAG_W'(out_center_q);

	always_ff @(posedge clk) begin
		neg_up_q <= diff_up[MAG_W-1];
		neg_lo_q <= diff_lo[MAG_W-1];
		mag_up_q <= diff_up[MAG_W-1] ? MAG_W'(-diff_up) : MAG_W'(diff_up);
		mag_lo_q <= diff_lo[MAG_W-1] ? MAG_W'(-diff_lo) : MAG_W'(diff_lo);
	end

	// pipeline control
	logic adv;
	logic vld_so;
	assign adv        = !vld_so || mapped.ready;
	assign axis.ready = adv;

	// stage 1: clamp, side, distance and span
	logic signed [SB-1:0] clip_hi, clip;
	logic signed [SW-1:0] delta, span;
	flags_t               flags_nx;

	assign clip_hi = (axis.sample > in_max_q) ? in_max_q : axis.sample;
	assign clip    = (clip_hi < in_min_q) ? in_min_q : clip_hi;

	always_comb begin
		flags_nx.upper = (clip >= in_center_q);
		if (flags_nx.upper) begin
			delta = SW'(clip) - SW'(in_center_q);
			span  = SW'(in_max_q) - SW'(in_center_q);
		end else begin
			delta = SW'(in_center_q) - SW'(clip);
			span  = SW'(in_center_q) - SW'(in_min_q);
		end
		flags_nx.zero = (span == '0);
		flags_nx.neg  = span[SW-1];
		flags_nx.sat  = (delta[SB-1:0] > span[SB-1:0]);
	end

	logic          vld_s1;
	flags_t        flags_s1;
	logic [SB-1:0] num_s1, span_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= axis.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s1 <= flags_nx;
			num_s1   <= delta[SB-1:0];
			span_s1  <= span[SB-1:0];
		end
	end

	// restoring divider: F = (num << 30) / span, one quotient bit per stage
	logic [DIV_STEPS-1:0] dvld_sd;
	logic [SB-1:0]        drem_sd  [DIV_STEPS];
	logic [SB-1:0]        dspan_sd [DIV_STEPS];
	q_t                   dq_sd    [DIV_STEPS];
	flags_t               dflg_sd  [DIV_STEPS];

	logic [SB-1:0] drem_nx  [DIV_STEPS];
	logic [SB-1:0] dspan_nx [DIV_STEPS];
	q_t            dq_nx    [DIV_STEPS];
	flags_t        dflg_nx  [DIV_STEPS];

	genvar k;
	for (k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [SB:0]   t;
		logic [SB-1:0] span_in;
		q_t            q_in;
		flags_t        flg_in;
		logic          ge;

		if (k == 0) begin : g_first
			assign t       = {1'b0, num_s1};
			assign span_in = span_s1;
			assign q_in    = '0;
			assign flg_in  = flags_s1;
		end else begin : g_next
			assign t       = {drem_sd[k-1], 1'b0};
			assign span_in = dspan_sd[k-1];
			assign q_in    = dq_sd[k-1];
			assign flg_in  = dflg_sd[k-1];
		end

		assign ge          = (t >= {1'b0, span_in});
		assign drem_nx[k]  = ge ? SB'(t - {1'b0, span_in}) : SB'(t);
		assign dspan_nx[k] = span_in;
		assign dq_nx[k]    = {q_in[Q_W-2:0], ge};
		assign dflg_nx[k]  = flg_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_sd <= '0;
		end else if (adv) begin
			dvld_sd <= {dvld_sd[DIV_STEPS-2:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < DIV_STEPS; i++) begin
				drem_sd[i]  <= drem_nx[i];
				dspan_sd[i] <= dspan_nx[i];
				dq_sd[i]    <= dq_nx[i];
				dflg_sd[i]  <= dflg_nx[i];
			end
		end
	end

	flags_t div_flg;
	q_t     frac;
	side_t  side0;

	assign div_flg = dflg_sd[DIV_STEPS-1];
	assign frac    = (div_flg.zero || div_flg.neg) ? '0 :
	                 div_flg.sat ? ONE_Q : dq_sd[DIV_STEPS-1];

	always_comb begin
		side0          = '0;
		side0.upper    = div_flg.upper;
		side0.fault    = div_flg.zero;
		side0.roots[0] = frac;
	end

	// chained square roots: roots[u] = sqrt(roots[u-1] << 30)
	side_t uside [N_ROOTS+1];
	logic  uvld  [N_ROOTS+1];

	assign uside[0] = side0;
	assign uvld[0]  = dvld_sd[DIV_STEPS-1];

	genvar u;
	for (u = 1; u <= N_ROOTS; u++) begin : g_root
		side_t so;
		side_t nx;
		q_t    rt;
		logic  ov;

		acem_isqrt u_isqrt (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_vld   (uvld[u-1]),
			.radicand (uside[u-1].roots[u-1]),
			.in_side  (uside[u-1]),
			.out_vld  (ov),
			.root     (rt),
			.out_side (so)
		);

		always_comb begin
			nx          = so;
			nx.roots[u] = rt;
		end

		assign uside[u] = nx;
		assign uvld[u]  = ov;
	end

	// power: one exponent bit per stage
	logic [POW_STEPS-1:0] pvld_sp;
	q_t                   p_sp     [POW_STEPS];
	q_t                   sq_sp    [POW_STEPS];
	side_t                pside_sp [POW_STEPS];

	q_t    p_nx     [POW_STEPS];
	q_t    sq_nx    [POW_STEPS];
	side_t pside_nx [POW_STEPS];

	genvar b;
	for (b = 0; b < POW_STEPS; b++) begin : g_pow
		q_t                 p_in;
		q_t                 sq_in;
		side_t              side_in;
		q_t                 x;
		logic [2*Q_W-1:0]   px;

		if (b == 0) begin : g_first
			assign p_in    = ONE_Q;
			assign sq_in   = uside[N_ROOTS].roots[0];
			assign side_in = uside[N_ROOTS];
		end else begin : g_next
			assign p_in    = p_sp[b-1];
			assign sq_in   = sq_sp[b-1];
			assign side_in = pside_sp[b-1];
		end

		if (b < N_ROOTS) begin : g_rootbit
			assign x        = side_in.roots[N_ROOTS-b];
			assign sq_nx[b] = sq_in;
		end else begin : g_sqbit
			logic [2*Q_W-1:0] sx;
			assign x        = sq_in;
			assign sx       = sq_in * sq_in;
			assign sq_nx[b] = sx[Q_FRAC +: Q_W];
		end

		assign px          = p_in * x;
		assign p_nx[b]     = exp_eff[b] ? px[Q_FRAC +: Q_W] : p_in;
		assign pside_nx[b] = side_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_sp <= '0;
		end else if (adv) begin
			pvld_sp <= {pvld_sp[POW_STEPS-2:0], uvld[N_ROOTS]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < POW_STEPS; i++) begin
				p_sp[i]     <= p_nx[i];
				sq_sp[i]    <= sq_nx[i];
				pside_sp[i] <= pside_nx[i];
			end
		end
	end

	// scale by endpoint delta
	side_t              pow_side;
	logic [MAG_W-1:0]   mag_sel;
	logic [Q_W+MAG_W-1:0] prod;

	assign pow_side = pside_sp[POW_STEPS-1];
	assign mag_sel  = pow_side.upper ? mag_up_q : mag_lo_q;
	assign prod     = p_sp[POW_STEPS-1] * mag_sel;

	logic             vld_sm;
	logic [MAG_W-1:0] q_sm;
	logic             neg_sm;
	logic             fault_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sm <= 1'b0;
		end else if (adv) begin
			vld_sm <= pvld_sp[POW_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_sm     <= prod[Q_FRAC +: MAG_W];
			neg_sm   <= pow_side.upper ? neg_up_q : neg_lo_q;
			fault_sm <= pow_side.fault;
		end
	end

	// offset from center, clamp, output register
	logic signed [SUM_W-1:0] ctr, qx, sum, lim_hi, lim_lo, c1, c2;
	logic signed [OUT_W-1:0] res;

	assign ctr    = SUM_W'(out_center_q);
	assign qx     = signed'({1'b0, q_sm});
	assign sum    = neg_sm ? (ctr - qx) : (ctr + qx);
	assign lim_hi = SUM_W'(out_max_q);
	assign lim_lo = SUM_W'(out_min_q);
	assign c1     = (sum > lim_hi) ? lim_hi : sum;
	assign c2     = (c1 < lim_lo) ? lim_lo : c1;
	assign res    = fault_sm ? out_center_q : c2[OUT_W-1:0];

	logic signed [OUT_W-1:0] val_so;
	logic                    fault_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_so <= 1'b0;
		end else if (adv) begin
			vld_so <= vld_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_so   <= res;
			fault_so <= fault_sm;
		end
	end

	assign mapped.valid        = vld_so;
	assign mapped.mapped_value = val_so;
	assign mapped.span_fault   = fault_so;

`ifndef SYNTHESIS
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s1) && $stable(dvld_sd) && $stable(pvld_sp) && $stable(vld_sm))
		else $error("pipeline valid bits moved during a stall");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		dvld_sd[DIV_STEPS-1] && !div_flg.zero && !div_flg.neg && !div_flg.sat
		|-> dq_sd[DIV_STEPS-1] <= ONE_Q)
		else $error("divider quotient above one");

	a_pow_range: assert property (@(posedge clk) disable iff (!arst_n)
		pvld_sp[POW_STEPS-1] |-> p_sp[POW_STEPS-1] <= ONE_Q)
		else $error("expo power above one");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_sm |=> vld_so)
		else $error("scaled transaction not loaded into output register");
`endif

endmodule
`default_nettype wire

// ===== hdl/acem_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined integer square root of (radicand << 30), one result bit per stage.
module acem_isqrt import acem_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire logic  in_vld,
	input  wire q_t    radicand,
	input  wire side_t in_side,
	output logic       out_vld,
	output q_t         root,
	output side_t      out_side
);

	localparam int STEPS = Q_W;
	localparam int REM_W = Q_W + 2;
	localparam int X_W   = 2 * Q_W;

	logic [STEPS-1:0] vld_s;
	logic [REM_W-1:0] rem_s  [STEPS];
	q_t               root_s [STEPS];
	q_t               rad_s  [STEPS];
	side_t            side_s [STEPS];

	logic [REM_W-1:0] rem_nx  [STEPS];
	q_t               root_nx [STEPS];
	q_t               rad_nx  [STEPS];
	side_t            side_nx [STEPS];

	genvar j;
	for (j = 0; j < STEPS; j++) begin : g_step
		logic [REM_W-1:0] rem_in;
		q_t               root_in;
		q_t               rad_in;
		side_t            side_in;
		logic [X_W-1:0]   x;
		logic [REM_W+1:0] rs;
		logic [REM_W+1:0] trial;
		logic             ge;

		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = radicand;
			assign side_in = in_side;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign rad_in  = rad_s[j-1];
			assign side_in = side_s[j-1];
		end

		assign x     = {1'b0, rad_in, {Q_FRAC{1'b0}}};
		assign rs    = {rem_in, x[X_W-1-2*j -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = (rs >= trial);

		assign rem_nx[j]  = ge ? REM_W'(rs - trial) : REM_W'(rs);
		assign root_nx[j] = {root_in[Q_W-2:0], ge};
		assign rad_nx[j]  = rad_in;
		assign side_nx[j] = side_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[STEPS-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < STEPS; k++) begin
				rem_s[k]  <= rem_nx[k];
				root_s[k] <= root_nx[k];
				rad_s[k]  <= rad_nx[k];
				side_s[k] <= side_nx[k];
			end
		end
	end

	assign out_vld  = vld_s[STEPS-1];
	assign root     = root_s[STEPS-1];
	assign out_side = side_s[STEPS-1];

endmodule
`default_nettype wire

// ===== tb/axis_center_expo_mapper_test.sv =====
`timescale 1ns / 1ps
// Self-checking test of the axis center/expo mapper: predicted values vs. stream results.
module axis_center_expo_mapper_test;
	import acem_pkg::*;

	localparam int SB = 16;
	localparam int LATENCY = 422;
	localparam longint LIMIT = 2000000;

	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		logic                    fault;
	} mapped_t;

	logic clk = 0;
	logic arst_n = 0;
	logic wr_en = 0;
	reg_idx_t wr_index = REG_IN_MIN;
	logic [OUT_W-1:0] wr_data = '0;

	acem_sample_if #(.SAMPLE_BITS(SB)) axis ();
	acem_result_if mapped ();

	axis_center_expo_mapper #(.SAMPLE_BITS(SB)) dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .axis(axis.sink), .mapped(mapped.source)
	);

	// predictor copy of the registers
	logic signed [SB-1:0] cal_in_min = 0, cal_in_max = 1023, cal_in_center = 512;
	logic signed [31:0] cal_out_min = -65536, cal_out_center = 0, cal_out_max = 65536;
	logic cal_reverse = 0;
	logic [15:0] cal_expo = 16'd4096;

	mapped_t expected_q[$];
	int errors = 0;
	int checked = 0;
	int faults_seen = 0;
	longint cycles = 0;
	logic stall_mode = 0;

	initial begin
		axis.valid = 0;
		axis.sample = '0;
		mapped.ready = 0;
	end

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] curve_power(logic [63:0] f, logic [15:0] e);
		logic [63:0] roots[13];
		logic [63:0] sq, p, x;
		sq = f;
		p = 64'd1 << 30;
		roots[0] = f;
		for (int i = 1; i <= 12; i++) roots[i] = isqrt(roots[i-1] << 30);
		for (int b = 0; b < 16; b++) begin
			if (b < 12) begin
				x = roots[12-b];
			end else begin
				if (b > 12) sq = (sq * sq) >> 30;
				x = sq;
			end
			if (e[b]) p = (p * x) >> 30;
		end
		return p;
	endfunction

	function automatic mapped_t calibrate(logic signed [SB-1:0] raw);
		mapped_t r;
		longint v, lo, hi, c, num, span, endp, diff, res;
		logic [63:0] f, p, mag, q;
		logic [15:0] e;
		logic upper;
		v = raw; lo = cal_in_min; hi = cal_in_max; c = cal_in_center;
		e = (cal_expo <= EXP_TINY) ? EXP_ONE : cal_expo;
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		upper = v >= c;
		if (upper) begin
			num = v - c; span = hi - c;
		end else begin
			num = c - v; span = c - lo;
		end
		if (span == 0) begin
			r.value = cal_out_center;
			r.fault = 1;
			return r;
		end
		if (span < 0) f = 0;
		else begin
			f = (64'(num) << 30) / 64'(span);
			if (f > (64'd1 << 30)) f = 64'd1 << 30;
		end
		p = curve_power(f, e);
		if (cal_reverse) endp = upper ? cal_out_min : cal_out_max;
		else endp = upper ? cal_out_max : cal_out_min;
		diff = endp - longint'(cal_out_center);
		mag = (diff < 0) ? 64'(-diff) : 64'(diff);
		q = (p * mag) >> 30;
		res = (diff < 0) ? cal_out_center - longint'(q) : cal_out_center + longint'(q);
		if (res > cal_out_max) res = cal_out_max;
		if (res < cal_out_min) res = cal_out_min;
		r.value = res[31:0];
		r.fault = 0;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch #%0d: %s got %0d expected %0d", errors, what, got, want);
	endtask

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		mapped_t want;
		if (mapped.valid && mapped.ready) begin
			if (expected_q.size() == 0) begin
				report("unexpected transaction", mapped.mapped_value, 0);
			end else begin
				want = expected_q.pop_front();
				checked++;
				if (mapped.span_fault) faults_seen++;
				if (mapped.mapped_value !== want.value)
					report("mapped_value", mapped.mapped_value, want.value);
				if (mapped.span_fault !== want.fault)
					report("span_fault", mapped.span_fault, want.fault);
			end
		end
		if (!arst_n) mapped.ready <= 0;
		else if (!stall_mode) mapped.ready <= 1;
		else mapped.ready <= (cycles % 7 < 4) ^ ($urandom_range(0, 5) == 0);
	end

	task automatic send_sample(logic signed [SB-1:0] raw);
		axis.valid <= 1;
		axis.sample <= raw;
		expected_q.push_back(calibrate(raw));
		do @(posedge clk); while (!axis.ready);
	endtask

	task automatic idle_cycles(int n);
		axis.valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		idle_cycles(1);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 0;
		@(posedge clk);
		case (idx)
			REG_IN_MIN: cal_in_min = data[SB-1:0];
			REG_IN_MAX: cal_in_max = data[SB-1:0];
			REG_IN_CENTER: cal_in_center = data[SB-1:0];
			REG_OUT_MIN: cal_out_min = data;
			REG_OUT_CENTER: cal_out_center = data;
			REG_OUT_MAX: cal_out_max = data;
			REG_REVERSE: cal_reverse = data[0];
			REG_EXPONENT: cal_expo = data[15:0];
			default: ;
		endcase
	endtask

	task automatic set_calibration(int imin, int imax, int icen, int omin, int ocen, int omax,
			bit rev, int ex);
		write_reg(REG_IN_MIN, imin);
		write_reg(REG_IN_MAX, imax);
		write_reg(REG_IN_CENTER, icen);
		write_reg(REG_OUT_MIN, omin);
		write_reg(REG_OUT_CENTER, ocen);
		write_reg(REG_OUT_MAX, omax);
		write_reg(REG_REVERSE, rev);
		write_reg(REG_EXPONENT, ex);
	endtask

	task automatic random_burst_send(int n, int lo, int hi);
		int sent;
		sent = 0;
		while (sent < n) begin
			repeat ($urandom_range(1, 12)) begin
				if (sent < n) begin
					if ($urandom_range(0, 3) == 0) send_sample($urandom());
					else send_sample($urandom_range(lo, hi) - 32768);
					sent++;
				end
			end
			if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 5));
		end
	endtask

	task automatic test_reset_defaults();
		send_sample(-32768);
		send_sample(32767);
		send_sample(0);
		send_sample(512);
		send_sample(511);
		send_sample(1023);
		send_sample(256);
		drain();
	endtask

	task automatic test_special_cases();
		// zero span on upper side, tiny exponent, reversed
		set_calibration(-100, 100, 100, -65536, 1000, 65536, 1, 40);
		send_sample(200);
		send_sample(-50);
		send_sample(-100);
		drain();
		// negative span, inverted input and output ranges
		set_calibration(500, -500, 800, 65536, -65536, -65536, 0, 8192);
		send_sample(0);
		send_sample(1000);
		send_sample(-1000);
		drain();
		// extreme ranges and exponents
		set_calibration(-32768, 32767, 0, 32'h8000_0000, 0, 32'h7fff_ffff, 0, 65535);
		send_sample(-32768);
		send_sample(32767);
		send_sample(1);
		send_sample(-1);
		send_sample(16384);
		drain();
		set_calibration(-32768, 32767, -32768, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 1, 41);
		send_sample(-32768);
		send_sample(0);
		send_sample(32767);
		drain();
		write_reg(REG_EXPONENT, 0);
		send_sample(100);
		send_sample(-20000);
		drain();
	endtask

	task automatic test_random_settings();
		int lo, hi, c, o1, o2, o3;
		for (int phase = 0; phase < 10; phase++) begin
			stall_mode = phase % 3 != 0;
			lo = $urandom_range(0, 40000) - 32768;
			hi = $urandom_range(0, 40000) - 7232;
			if (hi > 32767) hi = 32767;
			c = $urandom_range(0, 7) == 0 ? lo : (lo + hi) / 2 + $urandom_range(0, 64) - 32;
			o1 = $urandom();
			o2 = $urandom();
			o3 = $urandom();
			if (phase % 4 != 3) begin
				o1 = -($urandom_range(1, 1 << 24));
				o2 = $urandom_range(0, 4096) - 2048;
				o3 = $urandom_range(1, 1 << 24);
			end
			set_calibration(lo, hi, c, o1, o2, o3, $urandom_range(0, 1),
				phase == 9 ? $urandom_range(0, 40) : $urandom_range(0, 65535));
			random_burst_send(110, lo + 32768 - 200 < 0 ? 0 : lo + 32768 - 200,
				hi + 32768 + 200 > 65535 ? 65535 : hi + 32768 + 200);
			if (phase == 5) begin
				idle_cycles(1);
				while (expected_q.size() != 0) @(posedge clk);
			end
			drain();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_reset_defaults();
		test_special_cases();
		test_random_settings();
		$display("covered %0d results (%0d with span fault) over directed and random calibrations",
			checked, faults_seen);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
